[rtl/region_geometric_mean_macros.svh]
// Assertion macros used by the region geometric mean datapath.
`ifndef REGION_GEOMETRIC_MEAN_MACROS_SVH
`define REGION_GEOMETRIC_MEAN_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RGM_ASSERT_SAME(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);
`define RGM_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);
`else
`define RGM_ASSERT_SAME(lbl, clk, rst_n, a, b, msg)
`define RGM_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

[rtl/rgm_pkg.sv]
// Package with constants, codes and controller/datapath interface types.
package rgm_pkg;
    localparam int MAX_N      = 64;
    localparam int FRAC_BITS  = 16;
    localparam int LOG_FRAC   = 26;
    localparam int ITEM_LIMIT = 4096;
    localparam int LOG_STEPS  = 26;
    localparam int DIV_STEPS  = 45;
    localparam int SQRT_STEPS = 32;
    localparam int EXP_STEPS  = 26;

    localparam logic [2:0] MODE_ALL   = 3'd0;
    localparam logic [2:0] MODE_ROW   = 3'd1;
    localparam logic [2:0] MODE_COL   = 3'd2;
    localparam logic [2:0] MODE_DIAG  = 3'd3;
    localparam logic [2:0] MODE_BELOW = 3'd4;
    localparam logic [2:0] MODE_ANTI  = 3'd5;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_LINE = 2'd1;
    localparam logic [1:0] REG_SIZE = 2'd2;

    typedef struct packed {
        logic ready;
        logic norm_shift;
        logic sq_mul;
        logic sq_upd;
        logic log_acc;
        logic div_init;
        logic div_step;
        logic exp_init;
        logic sqrt_init;
        logic sqrt_step;
        logic emul;
        logic eupd;
        logic fin;
    } rgm_cmd_t;

    typedef struct packed {
        logic accept;
        logic item_log;
        logic last;
        logic norm_done;
        logic tally_zero;
        logic out_free;
    } rgm_status_t;
endpackage

[rtl/rgm_ctrl.sv]
// Controller state machine sequencing log2, division and exp2 steps.
module rgm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  rgm_pkg::rgm_status_t st,
    output rgm_pkg::rgm_cmd_t    cmd
);
    import rgm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_SQ, S_SQUPD, S_ACC, S_CHK, S_DIV,
        S_EXPI, S_SQI, S_SQS, S_EMUL, S_EUPD, S_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [4:0] kcnt_reg, kcnt_next;
    logic       last_reg, last_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kcnt_next  = kcnt_reg;
        last_next  = last_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (st.accept)
                begin
                    last_next = st.last;
                    if (st.item_log)
                        state_next = S_NORM;
                    else if (st.last)
                        state_next = S_CHK;
                end
            end
            S_NORM:
            begin
                if (st.norm_done)
                begin
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
                else
                    cmd.norm_shift = 1'b1;
            end
            S_SQ:
            begin
                cmd.sq_mul = 1'b1;
                state_next = S_SQUPD;
            end
            S_SQUPD:
            begin
                cmd.sq_upd = 1'b1;
                if (cnt_reg == 6'(LOG_STEPS - 1))
                    state_next = S_ACC;
                else
                begin
                    cnt_next   = cnt_reg + 6'd1;
                    state_next = S_SQ;
                end
            end
            S_ACC:
            begin
                cmd.log_acc = 1'b1;
                state_next  = last_reg ? S_CHK : S_IDLE;
            end
            S_CHK:
            begin
                if (st.tally_zero)
                    state_next = S_FIN;
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                    state_next = S_EXPI;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_EXPI:
            begin
                cmd.exp_init = 1'b1;
                kcnt_next    = '0;
                state_next   = S_SQI;
            end
            S_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQS;
            end
            S_SQS:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                    state_next = S_EMUL;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_EMUL:
            begin
                cmd.emul   = 1'b1;
                state_next = S_EUPD;
            end
            S_EUPD:
            begin
                cmd.eupd = 1'b1;
                if (kcnt_reg == 5'(EXP_STEPS - 1))
                    state_next = S_FIN;
                else
                begin
                    kcnt_next  = kcnt_reg + 5'd1;
                    state_next = S_SQI;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            kcnt_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            kcnt_reg  <= kcnt_next;
            last_reg  <= last_next;
        end
    end
endmodule

[rtl/rgm_datapath.sv]
// Datapath: counters, region select, log2, divider, exp2 and output register.
`include "region_geometric_mean_macros.svh"
module rgm_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [6:0]           cfg_data,
    input  logic                 s_tvalid,
    input  logic [31:0]          s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,
    input  rgm_pkg::rgm_cmd_t    cmd,
    output rgm_pkg::rgm_status_t st
);
    import rgm_pkg::*;

    logic [2:0]         mode_reg;
    logic [5:0]         line_reg;
    logic [6:0]         size_reg;
    logic [5:0]         row_reg, col_reg;
    logic [12:0]        item_reg, tally_reg;
    logic signed [44:0] sum_reg;
    logic [31:0]        m_reg;
    logic [4:0]         p_reg;
    logic [25:0]        frac_reg;
    logic [63:0]        sq_reg;
    logic [12:0]        rem_reg;
    logic [44:0]        quo_reg;
    logic               neg_reg;
    logic [19:0]        ipart_reg;
    logic [25:0]        fpart_reg;
    logic [32:0]        root_reg;
    logic [31:0]        prod_reg;
    logic [63:0]        eprod_reg;
    logic [63:0]        x_reg, res_reg, bit_reg;
    logic               ovalid_reg;
    logic [30:0]        omean_reg;
    logic [12:0]        ocount_reg;
    logic               onopos_reg;

    logic [6:0]  n;
    logic [13:0] nn;
    logic        accept, under_limit, in_mat, sel, positive;
    logic [6:0]  col_inc;
    logic signed [5:0]  pe;
    logic signed [44:0] logv;
    logic [44:0] mag;
    logic [13:0] dshift;
    logic [45:0] avg;
    logic [63:0] sq_t;
    logic signed [20:0] rsh;
    logic [30:0] mean;
    logic        out_free;

    always_comb
    begin
        if (size_reg == 7'd0)
            n = 7'd1;
        else if (size_reg > 7'(MAX_N))
            n = 7'(MAX_N);
        else
            n = size_reg;
        nn          = 14'(n) * 14'(n);
        accept      = s_tvalid && cmd.ready;
        under_limit = item_reg < 13'(ITEM_LIMIT);
        in_mat      = {1'b0, item_reg} < nn;
        positive    = !s_tdata[31] && (s_tdata != 32'd0);
        case (mode_reg)
            MODE_ALL:   sel = 1'b1;
            MODE_ROW:   sel = in_mat && (row_reg == line_reg);
            MODE_COL:   sel = in_mat && (col_reg == line_reg);
            MODE_DIAG:  sel = in_mat && (row_reg == col_reg);
            MODE_BELOW: sel = in_mat && (col_reg < row_reg);
            MODE_ANTI:  sel = in_mat && ({1'b0, row_reg} < n)
                              && ({1'b0, col_reg} == n - 7'd1 - {1'b0, row_reg});
            default:    sel = 1'b0;
        endcase
        col_inc = {1'b0, col_reg} + 7'd1;
        pe      = $signed({1'b0, p_reg}) - 6'sd16;
        logv    = $signed({{13{pe[5]}}, pe, frac_reg});
        mag     = sum_reg[44] ? 45'(-sum_reg) : 45'(sum_reg);
        dshift  = {rem_reg, quo_reg[44]};
        avg     = neg_reg ? 46'(-{1'b0, quo_reg}) : {1'b0, quo_reg};
        sq_t    = res_reg + bit_reg;
        rsh     = 21'sd15 - 21'($signed(ipart_reg));
        if ($signed(ipart_reg) > 20'sd15)
            mean = 31'h7FFF_FFFF;
        else if (rsh == 21'sd0)
            mean = prod_reg[31] ? 31'h7FFF_FFFF : prod_reg[30:0];
        else if (rsh >= 21'sd32)
            mean = 31'd0;
        else
            mean = 31'(prod_reg >> rsh[4:0]);
        out_free = !ovalid_reg || m_tready;
    end

    assign st.accept     = accept;
    assign st.item_log   = under_limit && positive && sel;
    assign st.last       = s_tlast;
    assign st.norm_done  = m_reg[31];
    assign st.tally_zero = (tally_reg == 13'd0);
    assign st.out_free   = out_free;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {3'b000, onopos_reg, ocount_reg, omean_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ALL;
            line_reg   <= '0;
            size_reg   <= 7'd1;
            row_reg    <= '0;
            col_reg    <= '0;
            item_reg   <= '0;
            tally_reg  <= '0;
            sum_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODE: mode_reg <= cfg_data[2:0];
                    REG_LINE: line_reg <= cfg_data[5:0];
                    REG_SIZE: size_reg <= cfg_data;
                    default:  ;
                endcase
            end
            if (accept && under_limit)
            begin
                item_reg <= item_reg + 13'd1;
                if (col_inc >= n)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 6'd1;
                end
                else
                    col_reg <= col_inc[5:0];
            end
            if (cmd.log_acc)
            begin
                sum_reg   <= sum_reg + logv;
                tally_reg <= tally_reg + 13'd1;
            end
            if (cmd.fin)
            begin
                row_reg    <= '0;
                col_reg    <= '0;
                item_reg   <= '0;
                tally_reg  <= '0;
                sum_reg    <= '0;
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_reg <= {s_tdata[30:0], 1'b0};
            p_reg <= 5'd30;
        end
        else if (cmd.norm_shift)
        begin
            m_reg <= {m_reg[30:0], 1'b0};
            p_reg <= p_reg - 5'd1;
        end
        else if (cmd.sq_upd)
            m_reg <= sq_reg[63] ? sq_reg[63:32] : sq_reg[62:31];
        if (accept)
            frac_reg <= '0;
        else if (cmd.sq_upd)
            frac_reg <= {frac_reg[24:0], sq_reg[63]};
        if (cmd.sq_mul)
            sq_reg <= 64'(m_reg) * 64'(m_reg);
        if (cmd.div_init)
        begin
            neg_reg <= sum_reg[44];
            rem_reg <= '0;
            quo_reg <= mag + (sum_reg[44] ? 45'(tally_reg - 13'd1) : 45'd0);
        end
        else if (cmd.div_step)
        begin
            if (dshift >= {1'b0, tally_reg})
            begin
                rem_reg <= 13'(dshift - {1'b0, tally_reg});
                quo_reg <= {quo_reg[43:0], 1'b1};
            end
            else
            begin
                rem_reg <= dshift[12:0];
                quo_reg <= {quo_reg[43:0], 1'b0};
            end
        end
        if (cmd.exp_init)
        begin
            ipart_reg <= avg[45:26];
            fpart_reg <= avg[25:0];
            root_reg  <= 33'h1_0000_0000;
            prod_reg  <= 32'h8000_0000;
        end
        else if (cmd.emul)
        begin
            root_reg  <= res_reg[32:0];
            eprod_reg <= 64'(prod_reg) * 64'(res_reg[31:0]);
        end
        else if (cmd.eupd)
        begin
            if (fpart_reg[25])
                prod_reg <= eprod_reg[62:31];
            fpart_reg <= {fpart_reg[24:0], 1'b0};
        end
        if (cmd.sqrt_init)
        begin
            x_reg   <= 64'(root_reg) << 31;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (cmd.sqrt_step)
        begin
            if (x_reg >= sq_t)
            begin
                x_reg   <= x_reg - sq_t;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.fin)
        begin
            if (tally_reg == 13'd0)
            begin
                omean_reg  <= '0;
                ocount_reg <= '0;
                onopos_reg <= 1'b1;
            end
            else
            begin
                omean_reg  <= mean;
                ocount_reg <= tally_reg;
                onopos_reg <= 1'b0;
            end
        end
    end

    `RGM_ASSERT_SAME(a_tally_le_items, clk, rst_n, 1'b1, tally_reg <= item_reg, "tally exceeds items")
    `RGM_ASSERT_SAME(a_nopos_count, clk, rst_n, ovalid_reg && onopos_reg, ocount_reg == 13'd0, "flag with count")
    `RGM_ASSERT_NEXT(a_fin_clears, clk, rst_n, cmd.fin, tally_reg == 13'd0 && item_reg == 13'd0, "set not cleared")
endmodule

[rtl/region_geometric_mean.sv]
// Top level of the region geometric mean block.
// An unselected element is only accepted; a selected positive one is accepted, normalized,
// passed through the log2 squaring steps and accumulated into the sum.
// The last element then adds a tally check, the bit-serial divider, the exp2 steps, each built
// on a bit-serial square root, and the output step; an empty selection skips to the output step.
// rst_n clears counters, sums and the configuration (mode 0, line 0, size 1) at once.
module region_geometric_mean (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // element_value[31:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // mean_value[30:0], positive_count[43:31], no_positive[44]
);
    import rgm_pkg::*;

    rgm_cmd_t    cmd;
    rgm_status_t st;

    assign s_tready = cmd.ready;

    rgm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    rgm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .st        (st)
    );
endmodule

[tb/tb_region_geometric_mean.sv]
// Self-checking testbench for the region geometric mean block with a scoreboard class.
module tb_region_geometric_mean;
    timeunit 1ns;
    timeprecision 1ps;
    import rgm_pkg::*;

    localparam int WATCHDOG_LIMIT = 50000;
    localparam int DRAIN_CYCLES   = 1100;
    localparam int TARGET_ITEMS   = 650;

    class mean_scoreboard;
        logic [2:0]      mode;
        logic [5:0]      line;
        logic [6:0]      size;
        int unsigned     row;
        int unsigned     col;
        int unsigned     items;
        int unsigned     tally;
        longint          log_acc;
        logic [47:0]     pending[$];

        function new();
            mode = MODE_ALL;
            line = 0;
            size = 1;
            clear();
        endfunction

        function void clear();
            row = 0;
            col = 0;
            items = 0;
            tally = 0;
            log_acc = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [6:0] d);
            case (idx)
                REG_MODE: mode = d[2:0];
                REG_LINE: line = d[5:0];
                REG_SIZE: size = d;
                default: ;
            endcase
        endfunction

        function int unsigned side();
            if (size == 0)
                return 1;
            if (size > MAX_N)
                return MAX_N;
            return size;
        endfunction

        function longint log2_fixed(logic [31:0] v);
            int p;
            longint unsigned m;
            longint unsigned sq;
            longint frac;
            p = 30;
            frac = 0;
            while (p > 0 && !v[p])
                p--;
            m = longint'({32'b0, v}) << (31 - p);
            for (int k = 0; k < LOG_FRAC; k++)
            begin
                sq = m * m;
                frac = frac << 1;
                if (sq[63])
                begin
                    frac = frac | 1;
                    m = sq >> 32;
                end
                else
                    m = sq >> 31;
            end
            return longint'(p - FRAC_BITS) * (longint'(1) << LOG_FRAC) + frac;
        endfunction

        function longint unsigned isqrt(longint unsigned x);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function logic [30:0] exp2_fixed(longint avg);
            longint unsigned biased;
            longint unsigned fpart;
            longint unsigned root;
            longint unsigned prod;
            longint unsigned val;
            longint unsigned mean_max;
            int ipart;
            int shift;
            mean_max = 64'h7FFF_FFFF;
            biased = avg + (longint'(64) << LOG_FRAC);
            ipart = int'(biased >> LOG_FRAC) - 64;
            fpart = biased & ((64'd1 << LOG_FRAC) - 1);
            root = 64'd1 << 32;
            prod = 64'd1 << 31;
            for (int k = 1; k <= LOG_FRAC; k++)
            begin
                root = isqrt(root << 31);
                if ((fpart >> (LOG_FRAC - k)) & 1)
                    prod = (prod * root) >> 31;
            end
            shift = ipart + FRAC_BITS - 31;
            if (shift > 0)
            begin
                if (shift >= 32 || prod > (mean_max >> shift))
                    return mean_max[30:0];
                val = prod << shift;
            end
            else
                val = (-shift >= 64) ? 0 : (prod >> (-shift));
            return (val > mean_max) ? mean_max[30:0] : val[30:0];
        endfunction

        function bit selected(int unsigned n);
            if (mode == MODE_ALL)
                return 1;
            if (items >= n * n)
                return 0;
            case (mode)
                MODE_ROW:   return row == line;
                MODE_COL:   return col == line;
                MODE_DIAG:  return row == col;
                MODE_BELOW: return col < row;
                MODE_ANTI:  return row < n && col == n - 1 - row;
                default:    return 0;
            endcase
        endfunction

        function void note_element(logic [31:0] v, logic last);
            int unsigned n;
            longint q;
            logic [47:0] res;
            n = side();
            if (items < ITEM_LIMIT)
            begin
                if (v != 0 && !v[31] && selected(n))
                begin
                    log_acc += log2_fixed(v);
                    tally++;
                end
                items++;
                col++;
                if (col >= n)
                begin
                    col = 0;
                    row = (row + 1) % MAX_N;
                end
            end
            if (!last)
                return;
            res = '0;
            if (tally == 0)
                res[44] = 1'b1;
            else
            begin
                q = log_acc / longint'(tally);
                if (log_acc % longint'(tally) != 0 && log_acc < 0)
                    q--;
                res[30:0] = exp2_fixed(q);
                res[43:31] = tally[12:0];
            end
            pending.push_back(res);
            clear();
        endfunction

        function string check_result(logic [47:0] got);
            logic [47:0] want;
            string msg;
            if (pending.size() == 0)
                return $sformatf("unexpected result %h", got);
            want = pending.pop_front();
            msg = "";
            if (got[30:0] !== want[30:0])
                msg = {msg, $sformatf(" mean_value got %h want %h", got[30:0], want[30:0])};
            if (got[43:31] !== want[43:31])
                msg = {msg, $sformatf(" positive_count got %0d want %0d",
                                      got[43:31], want[43:31])};
            if (got[44] !== want[44])
                msg = {msg, $sformatf(" no_positive got %b want %b", got[44], want[44])};
            return msg;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    mean_scoreboard sb = new();
    int  errors = 0;
    int  sent_items = 0;
    int  sent_sets = 0;
    int  got_results = 0;
    bit  quiet = 0;

    region_geometric_mean u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    task automatic report(string msg);
        $display("MISMATCH at %0t:%s", $realtime, msg);
        errors++;
    endtask

    task automatic set_regs(logic [6:0] mode, logic [6:0] line, logic [6:0] size);
        logic [6:0] vals[3];
        vals = '{mode, line, size};
        for (int i = 0; i < 3; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            sb.write_reg(2'(i), vals[i]);
        end
        cfg_index <= 2'd3;
        cfg_data <= 7'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send(logic [31:0] v, logic last);
        int gap;
        s_tdata <= v;
        s_tlast <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_element(v, last);
        sent_items++;
        if (last)
            sent_sets++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_element();
        case ($urandom_range(0, 11))
            0: return 32'h0;
            1: return {1'b1, 31'($urandom)};
            2: return 32'h7FFF_FFFF;
            3: return 32'h1;
            4: return 32'h8000_0000;
            5, 6: return 32'($urandom_range(32'h0000_4000, 32'h0004_0000));
            default: return {1'b0, 31'($urandom)} >> $urandom_range(0, 30);
        endcase
    endfunction

    task automatic send_set(int count);
        for (int i = 0; i < count; i++)
            send(pick_element(), i == count - 1);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                string msg;
                msg = sb.check_result(m_tdata);
                got_results++;
                if (msg != "")
                    report(msg);
            end
            if (quiet)
                m_tready <= 1'b1;
            else if ($urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int n;
        int count;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults after reset: single element sets and one two-element set.
        send(32'h0001_0000, 1'b1);
        send(32'h0, 1'b1);
        send(32'h7FFF_FFFF, 1'b0);
        send(32'h1, 1'b1);
        send(32'hFFFF_0000, 1'b1);
        s_tvalid <= 1'b0;
        for (int m = MODE_ROW; m <= MODE_ANTI; m++)
        begin
            wait_idle();
            set_regs(7'(m), 7'd1, 7'd2);
            send(32'h0002_0000, 1'b0);
            send(32'h0000_8000, 1'b0);
            send(32'h7FFF_FFFF, 1'b0);
            send(32'h0000_0001, 1'b1);
            s_tvalid <= 1'b0;
        end

        // A set that runs past the end of the matrix.
        wait_idle();
        set_regs(7'(MODE_BELOW), 7'd0, 7'd8);
        for (int i = 0; i < 70; i++)
            send((i % 9 == 5 || i >= 62) ? pick_element() : 32'h0001_0000 + 32'(i),
                 i == 69);
        s_tvalid <= 1'b0;

        while (sent_items < TARGET_ITEMS)
        begin
            if (sent_items > TARGET_ITEMS - 150)
                quiet = 1;
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                s_tvalid <= 1'b0;
                wait_idle();
                case ($urandom_range(0, 9))
                    0: n = 0;
                    1: n = 64;
                    2: n = $urandom_range(65, 127);
                    default: n = $urandom_range(1, 8);
                endcase
                set_regs(($urandom_range(0, 4) == 0) ? 7'($urandom_range(6, 7))
                                                     : 7'($urandom_range(0, 5)),
                         ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                     : 7'($urandom_range(0, 7)),
                         7'(n));
            end
            n = sb.side();
            if (n <= 8 && $urandom_range(0, 4) != 0)
                count = n * n + $urandom_range(0, 4) - 2;
            else
                count = $urandom_range(1, 20);
            send_set((count < 1) ? 1 : count);
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d sets in all region modes, unused modes, sizes 0 to 127 and",
                 sent_sets);
        $display("out-of-matrix elements; %0d results were checked.", got_results);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
